>>> rtl/core/pclp_pkg.sv
// Package: shared constants, codes and result types of the command line parser.
package pclp_pkg;

  // Coordinate accumulators hold at most 16 bits; the limit is the smaller of both.
  localparam int COORD_BITS = 16;
  localparam int ACC_BITS   = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam logic [ACC_BITS-1:0] SAT_LIM = {ACC_BITS{1'b1}};

  // Result queue depth; an item pushes up to two results.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_HEIGHT = 1'b1;
  localparam logic [15:0] CANVAS_WIDTH_RST  = 16'd1024;
  localparam logic [15:0] CANVAS_HEIGHT_RST = 16'd768;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_DROP,
    PH_X0,
    PH_X,
    PH_Y0,
    PH_Y,
    PH_C0,
    PH_C,
    PH_S,
    PH_KW_PX,
    PH_KW_SIZE,
    PH_KW_STATS,
    PH_KW_HELP,
    PH_KW_RESET
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SET_PIXEL,
    KIND_GET_PIXEL,
    KIND_SIZE,
    KIND_STATS,
    KIND_HELP,
    KIND_RESET,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_NO_X,
    ERR_NO_PARAM,
    ERR_NO_Y,
    ERR_NO_COLOR,
    ERR_BAD_LEN,
    ERR_UNKNOWN
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [31:0] color_rgba;
    err_t        error_code;
    logic        last_of_run;
  } res_t;

  // Results of one accepted item, in order.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

>>> rtl/core/pclp_if.sv
// Interfaces: input byte channel and result channel of the parser.
interface pclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       chunk_end;

  modport source (output valid, output text_byte, output chunk_end, input ready);
  modport sink   (input valid, input text_byte, input chunk_end, output ready);
endinterface

interface pclp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  logic [31:0] color_rgba;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output kind, output coord_x, output coord_y,
                  output color_rgba, output error_code, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input coord_x, input coord_y,
                  input color_rgba, input error_code, input last_of_run,
                  output ready);
endinterface

>>> rtl/core/pixel_command_line_parser_core.sv
// Top level: configuration registers, byte decoder and result queue.
// A result is queued when its byte is accepted, then offered from the queue head.
// Throughput: one byte per cycle while ready is high; a byte's two results leave in order.
// in_chan.ready is low while the four-entry result queue has fewer than two free entries.
// Reset (rst_n low, synchronous): parser idle, accumulators zero, queue empty,
// canvas width 1024 and height 768.
module pixel_command_line_parser_core import pclp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  pclp_in_if.sink                 in_chan,
  pclp_out_if.source              out_chan,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_wdata
);

  logic [15:0] canvas_width_r, canvas_width_nxt;
  logic [15:0] canvas_height_r, canvas_height_nxt;
  logic        room;
  logic        accept;
  push_t       push;
  res_t        head;

  // Decode configuration writes.
  always_comb begin
    canvas_width_nxt  = canvas_width_r;
    canvas_height_nxt = canvas_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:  canvas_width_nxt  = cfg_wdata;
        CFG_CANVAS_HEIGHT: canvas_height_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= CANVAS_WIDTH_RST;
      canvas_height_r <= CANVAS_HEIGHT_RST;
    end else begin
      canvas_width_r  <= canvas_width_nxt;
      canvas_height_r <= canvas_height_nxt;
    end
  end

  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;

  pclp_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .text_byte     (in_chan.text_byte),
    .chunk_end     (in_chan.chunk_end),
    .canvas_width  (canvas_width_r),
    .canvas_height (canvas_height_r),
    .push          (push)
  );

  pclp_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_chan.valid),
    .head       (head),
    .pop_ready  (out_chan.ready)
  );

  // Drive the result payload from the queue head.
  assign out_chan.kind        = head.kind;
  assign out_chan.coord_x     = head.coord_x;
  assign out_chan.coord_y     = head.coord_y;
  assign out_chan.color_rgba  = head.color_rgba;
  assign out_chan.error_code  = head.error_code;
  assign out_chan.last_of_run = head.last_of_run;

endmodule

>>> rtl/core/pclp_decode.sv
// Parser state registers and the per-byte decode step producing up to two results.
module pclp_decode import pclp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  text_byte,
  input  logic        chunk_end,
  input  logic [15:0] canvas_width,
  input  logic [15:0] canvas_height,
  output push_t       push
);

  localparam logic [7:0] NUL = 8'd0;
  localparam logic [7:0] LF  = 8'd10;
  localparam logic [7:0] CR  = 8'd13;

  typedef struct packed {
    logic       skip;
    logic       fail;
    phase_t     ph;
    logic [3:0] dc;
  } idle_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] color;
  } fin_t;

  phase_t              phase_r, phase_nxt;
  logic [ACC_BITS-1:0] x_acc_r, x_acc_nxt;
  logic [ACC_BITS-1:0] y_acc_r, y_acc_nxt;
  logic [31:0]         c_acc_r, c_acc_nxt;
  logic [3:0]          dc_r, dc_nxt;

  phase_t              step_ph;
  logic [ACC_BITS-1:0] step_xa;
  logic [ACC_BITS-1:0] step_ya;
  logic [31:0]         step_ca;
  logic [3:0]          step_dc;
  logic [1:0]          step_n;
  res_t                step_res [2];

  function automatic res_t mk_res(kind_t k, logic [15:0] x, logic [15:0] y,
                                  logic [31:0] c, err_t e);
    res_t r;
    r.kind        = k;
    r.coord_x     = x;
    r.coord_y     = y;
    r.color_rgba  = c;
    r.error_code  = e;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic [ACC_BITS-1:0] sat_digit(logic [ACC_BITS-1:0] acc,
                                                   logic [3:0] d);
    logic [ACC_BITS+3:0] v;
    v = (ACC_BITS+4)'(acc) * (ACC_BITS+4)'(10) + (ACC_BITS+4)'(d);
    return (v > (ACC_BITS+4)'(SAT_LIM)) ? SAT_LIM : v[ACC_BITS-1:0];
  endfunction

  // Hex digit value, valid flag in the top bit.
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] h;
    h = 5'd0;
    if (b >= "0" && b <= "9") h = {1'b1, b[3:0]};
    else if (b >= "A" && b <= "F") h = {1'b1, 4'(b - "A" + 8'd10)};
    else if (b >= "a" && b <= "f") h = {1'b1, 4'(b - "a" + 8'd10)};
    return h;
  endfunction

  function automatic logic [2:0] kw_len(phase_t p);
    logic [2:0] l;
    case (p)
      PH_KW_PX:    l = 3'd3;
      PH_KW_SIZE:  l = 3'd4;
      PH_KW_STATS: l = 3'd5;
      PH_KW_HELP:  l = 3'd4;
      PH_KW_RESET: l = 3'd5;
      default:     l = 3'd1;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(phase_t p, logic [2:0] k);
    logic [7:0] c;
    c = 8'd0;
    case (p)
      PH_KW_PX: begin
        case (k)
          3'd0: c = "P";
          3'd1: c = "X";
          3'd2: c = " ";
          default: c = 8'd0;
        endcase
      end
      PH_KW_SIZE: begin
        case (k)
          3'd0: c = "S";
          3'd1: c = "I";
          3'd2: c = "Z";
          3'd3: c = "E";
          default: c = 8'd0;
        endcase
      end
      PH_KW_STATS: begin
        case (k)
          3'd0: c = "S";
          3'd1: c = "T";
          3'd2: c = "A";
          3'd3: c = "T";
          3'd4: c = "S";
          default: c = 8'd0;
        endcase
      end
      PH_KW_HELP: begin
        case (k)
          3'd0: c = "H";
          3'd1: c = "E";
          3'd2: c = "L";
          3'd3: c = "P";
          default: c = 8'd0;
        endcase
      end
      PH_KW_RESET: begin
        case (k)
          3'd0: c = "R";
          3'd1: c = "E";
          3'd2: c = "S";
          3'd3: c = "E";
          3'd4: c = "T";
          default: c = 8'd0;
        endcase
      end
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // First byte of a command: skip NUL and line ends, open a keyword, or flag unknown.
  function automatic idle_t idle_step(logic [7:0] b);
    idle_t it;
    it = '{skip: 1'b0, fail: 1'b0, ph: PH_IDLE, dc: 4'd0};
    if (b == NUL || b == LF || b == CR) it.skip = 1'b1;
    else if (b == "P") begin it.ph = PH_KW_PX;    it.dc = 4'd1; end
    else if (b == "S") begin it.ph = PH_S;        it.dc = 4'd1; end
    else if (b == "H") begin it.ph = PH_KW_HELP;  it.dc = 4'd1; end
    else if (b == "R") begin it.ph = PH_KW_RESET; it.dc = 4'd1; end
    else it.fail = 1'b1;
    return it;
  endfunction

  // Expand the collected colour by its digit count.
  function automatic fin_t finish_color(logic [31:0] a, logic [3:0] n);
    fin_t f;
    f.ok    = 1'b1;
    f.color = 32'd0;
    if (n == 4'd2) f.color = {a[7:0], a[7:0], a[7:0], 8'hff};
    else if (n == 4'd6) f.color = {a[23:0], 8'hff};
    else if (n == 4'd8) f.color = a;
    else f.ok = 1'b0;
    return f;
  endfunction

  // Decode one byte, then close the chunk if marked.
  always_comb begin
    logic        dig;
    logic [4:0]  h;
    logic [2:0]  k;
    idle_t       it;
    fin_t        fin;
    logic [15:0] xo;
    logic [15:0] yo;
    dig = (text_byte >= "0" && text_byte <= "9");
    h   = hex_val(text_byte);
    k   = 3'd0;
    xo  = 16'd0;
    yo  = 16'd0;
    it  = idle_step(text_byte);
    fin = finish_color(c_acc_r, dc_r);
    step_ph = phase_r;
    step_xa = x_acc_r;
    step_ya = y_acc_r;
    step_ca = c_acc_r;
    step_dc = dc_r;
    step_n  = 2'd0;
    step_res[0] = '0;
    step_res[1] = '0;

    unique case (phase_r) inside
      PH_IDLE: begin
        if (!it.skip) begin
          if (it.fail) begin
            step_res[0] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_UNKNOWN);
            step_n  = 2'd1;
            step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
            step_dc = 4'd0;
          end else begin
            step_ph = it.ph;
            step_dc = it.dc;
          end
        end
      end
      PH_DROP: begin
        if (text_byte == LF) step_ph = PH_IDLE;
      end
      PH_X0, PH_X: begin
        if (dig) begin
          step_xa = sat_digit((phase_r == PH_X0) ? '0 : x_acc_r, text_byte[3:0]);
          step_ph = PH_X;
        end else if (phase_r == PH_X0 || text_byte == NUL || text_byte == LF) begin
          step_res[0] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0,
                               (phase_r == PH_X0) ? ERR_NO_X :
                               (text_byte == NUL) ? ERR_NO_PARAM : ERR_NO_Y);
          step_n  = 2'd1;
          step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
          step_dc = 4'd0;
        end else begin
          step_ph = PH_Y0;
        end
      end
      PH_Y0, PH_Y: begin
        if (dig) begin
          step_ya = sat_digit((phase_r == PH_Y0) ? '0 : y_acc_r, text_byte[3:0]);
          step_ph = PH_Y;
        end else if (phase_r == PH_Y0) begin
          step_res[0] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_NO_Y);
          step_n  = 2'd1;
          step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
          step_dc = 4'd0;
        end else if (text_byte == NUL || text_byte == LF || text_byte == CR) begin
          step_res[0] = mk_res(KIND_GET_PIXEL, 16'(x_acc_r), 16'(y_acc_r), 32'd0,
                               ERR_NONE);
          step_n  = 2'd1;
          step_ph = PH_IDLE;
        end else begin
          step_ph = PH_C0;
          step_ca = 32'd0;
          step_dc = 4'd0;
        end
      end
      PH_C0, PH_C: begin
        if (h[4]) begin
          step_ca = {c_acc_r[27:0], h[3:0]};
          if (dc_r < 4'd15) step_dc = dc_r + 4'd1;
          step_ph = PH_C;
        end else if (phase_r == PH_C0) begin
          step_res[0] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_NO_COLOR);
          step_n  = 2'd1;
          step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
          step_dc = 4'd0;
        end else if (!fin.ok) begin
          step_res[0] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_BAD_LEN);
          step_n  = 2'd1;
          step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
          step_dc = 4'd0;
        end else begin
          // Emit the pixel, then handle the ending byte as a new command start.
          step_res[0] = mk_res(KIND_SET_PIXEL, 16'(x_acc_r), 16'(y_acc_r), fin.color,
                               ERR_NONE);
          step_n  = 2'd1;
          step_ph = PH_IDLE;
          step_dc = 4'd0;
          if (!it.skip) begin
            if (it.fail) begin
              step_res[1] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_UNKNOWN);
              step_n  = 2'd2;
              step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
            end else begin
              step_ph = it.ph;
              step_dc = it.dc;
            end
          end
        end
      end
      PH_S: begin
        if (text_byte == "I") begin
          step_ph = PH_KW_SIZE;
          step_dc = 4'd2;
        end else if (text_byte == "T") begin
          step_ph = PH_KW_STATS;
          step_dc = 4'd2;
        end else begin
          step_res[0] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_UNKNOWN);
          step_n  = 2'd1;
          step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
          step_dc = 4'd0;
        end
      end
      PH_KW_PX, PH_KW_SIZE, PH_KW_STATS, PH_KW_HELP, PH_KW_RESET: begin
        k = (dc_r < 4'(kw_len(phase_r))) ? dc_r[2:0] : 3'd0;
        if (text_byte != kw_char(phase_r, k)) begin
          step_res[0] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_UNKNOWN);
          step_n  = 2'd1;
          step_ph = (text_byte == LF) ? PH_IDLE : PH_DROP;
          step_dc = 4'd0;
        end else if (4'(k) + 4'd1 < 4'(kw_len(phase_r))) begin
          step_dc = 4'(k) + 4'd1;
        end else if (phase_r == PH_KW_PX) begin
          step_ph = PH_X0;
          step_xa = '0;
          step_ya = '0;
          step_ca = 32'd0;
          step_dc = 4'd0;
        end else begin
          // Complete keyword: emit now, drop the rest of the line.
          xo = (phase_r == PH_KW_SIZE) ? canvas_width  : 16'd0;
          yo = (phase_r == PH_KW_SIZE) ? canvas_height : 16'd0;
          step_res[0] = mk_res((phase_r == PH_KW_SIZE)  ? KIND_SIZE  :
                               (phase_r == PH_KW_STATS) ? KIND_STATS :
                               (phase_r == PH_KW_HELP)  ? KIND_HELP  : KIND_RESET,
                               xo, yo, 32'd0, ERR_NONE);
          step_n  = 2'd1;
          step_ph = PH_DROP;
          step_dc = 4'd0;
        end
      end
      default: begin
        step_ph = PH_IDLE;
      end
    endcase

    // Close a pending command at chunk end.
    if (chunk_end) begin
      fin = finish_color(step_ca, step_dc);
      case (step_ph)
        PH_X0: begin
          step_res[step_n[0]] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_NO_X);
          step_n = step_n + 2'd1;
        end
        PH_X: begin
          step_res[step_n[0]] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_NO_PARAM);
          step_n = step_n + 2'd1;
        end
        PH_Y0: begin
          step_res[step_n[0]] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_NO_Y);
          step_n = step_n + 2'd1;
        end
        PH_Y: begin
          step_res[step_n[0]] = mk_res(KIND_GET_PIXEL, 16'(step_xa), 16'(step_ya),
                                       32'd0, ERR_NONE);
          step_n = step_n + 2'd1;
        end
        PH_C0: begin
          step_res[step_n[0]] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_NO_COLOR);
          step_n = step_n + 2'd1;
        end
        PH_C: begin
          if (fin.ok) begin
            step_res[step_n[0]] = mk_res(KIND_SET_PIXEL, 16'(step_xa), 16'(step_ya),
                                         fin.color, ERR_NONE);
          end else begin
            step_res[step_n[0]] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_BAD_LEN);
          end
          step_n = step_n + 2'd1;
        end
        PH_S, PH_KW_PX, PH_KW_SIZE, PH_KW_STATS, PH_KW_HELP, PH_KW_RESET: begin
          step_res[step_n[0]] = mk_res(KIND_ERROR, 16'd0, 16'd0, 32'd0, ERR_UNKNOWN);
          step_n = step_n + 2'd1;
        end
        default: begin
        end
      endcase
      step_ph = PH_IDLE;
      step_dc = 4'd0;
    end

    // Mark the final result of this item.
    step_res[0].last_of_run = (step_n == 2'd1);
    step_res[1].last_of_run = (step_n == 2'd2);
  end

  // Next state: advance only on an accepted item.
  always_comb begin
    phase_nxt = phase_r;
    x_acc_nxt = x_acc_r;
    y_acc_nxt = y_acc_r;
    c_acc_nxt = c_acc_r;
    dc_nxt    = dc_r;
    if (accept) begin
      phase_nxt = step_ph;
      x_acc_nxt = step_xa;
      y_acc_nxt = step_ya;
      c_acc_nxt = step_ca;
      dc_nxt    = step_dc;
    end
  end

  // Outputs: results pushed for an accepted item.
  always_comb begin
    push.cnt  = accept ? step_n : 2'd0;
    push.res0 = step_res[0];
    push.res1 = step_res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      x_acc_r <= '0;
      y_acc_r <= '0;
      c_acc_r <= 32'd0;
      dc_r    <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      x_acc_r <= x_acc_nxt;
      y_acc_r <= y_acc_nxt;
      c_acc_r <= c_acc_nxt;
      dc_r    <= dc_nxt;
    end
  end

  // Two results come only from a colour end or a chunk close.
  a_two_results_source: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (chunk_end || phase_r == PH_C))
    else $error("two results without colour end or chunk close");

  a_no_three_results: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3)
    else $error("more than two results for one item");

endmodule

>>> rtl/core/pclp_out_queue.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while pop_ready is high.
module pclp_out_queue import pclp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  output res_t  head,
  input  logic  pop_ready
);

  res_t                 q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic [QPTR_BITS-1:0] wr_ptr_1;
  logic                 pop;

  // Accept an item only when two entries are free.
  assign room       = (count_r <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign pop        = head_valid && pop_ready;
  assign wr_ptr_1   = wr_ptr_r + QPTR_BITS'(1);

  // Advance pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(pop);
    count_nxt  = count_r + QCNT_BITS'(push.cnt) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store results in order.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_ptr_r] <= push.res0;
    if (push.cnt == 2'd2) q_r[wr_ptr_1] <= push.res1;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("results pushed without free entries");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && !pop_ready && push.cnt == 2'd0) |=> $stable(count_r))
    else $error("queue count changed without push or pop");

endmodule
